### rtl/tkh_pkg.sv
// Package for the top-K min-heap core: sizes, operation codes and payload types.
// Used by top_k_min_heap_core and its testbench; depends on nothing else.
`timescale 1ns / 1ps

package tkh_pkg;

  localparam int CAPACITY  = 10;
  localparam int TAG_BITS  = 16;

  localparam int SCORE_W   = 32;
  localparam int IN_TAG_W  = 16;
  localparam int OUT_CNT_W = 4;

  // Heap index, entry count and child index widths.
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CH_W  = IDX_W + 2;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

  typedef struct packed {
    logic                      func;
    logic signed [SCORE_W-1:0] score;
    logic [IN_TAG_W-1:0]       tag;
  } item_t;

  typedef struct packed {
    logic                      accepted;
    logic                      valid_res;
    logic signed [SCORE_W-1:0] min_score;
    logic [IN_TAG_W-1:0]       min_tag;
    logic [OUT_CNT_W-1:0]      count;
  } result_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [TAG_BITS-1:0]       tag;
  } entry_t;

endpackage

### rtl/tkh_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
// Stand-alone; no package needed.
`timescale 1ns / 1ps

module tkh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/top_k_min_heap_core.sv
// Top-K min-heap core: sequencer that sifts entries through the heap memory.
// An extract on an empty heap finishes straight from idle. An insert reads its parent and climbs
// while smaller; on a full heap it reads the root and is dropped or replaces it. A replace or an
// extract sinks an entry level by level, reading the left child and then the right one.
// One transaction at a time; the next can be taken while done is high. Registered RAM reads set pace.
// Reset clears the count and the sequencer, not the heap RAM. Depends on tkh_pkg and tkh_ram.
`timescale 1ns / 1ps

module top_k_min_heap_core
  import tkh_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_ROOT     = 8'b0000_0010,
    S_EXT_ROOT = 8'b0000_0100,
    S_EXT_LAST = 8'b0000_1000,
    S_UP       = 8'b0001_0000,
    S_DN_L     = 8'b0010_0000,
    S_DN_R     = 8'b0100_0000,
    S_FIN      = 8'b1000_0000
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic [IDX_W-1:0]   pos, pos_next;
  logic [IDX_W-1:0]   best, best_next;
  entry_t             itm, itm_next;
  entry_t             bestv, bestv_next;
  entry_t             minv, minv_next;
  logic               acc, acc_next;
  logic               vld, vld_next;
  result_t            res_next;
  logic               finish;

  logic               ram_we, ram_re;
  logic [IDX_W-1:0]   ram_wa, ram_ra;
  entry_t             ram_wd, ram_rd;

  logic [CH_W-1:0]    left_c, right_c, cnt_c, sel_l;
  logic [IDX_W-1:0]   par_idx, sel_idx;
  entry_t             sel_v;
  entry_t             new_e;
  logic               cand_lt;

  tkh_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(CAPACITY)
  ) u_heap (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wa),
    .wr_data (ram_wd),
    .re      (ram_re),
    .rd_addr (ram_ra),
    .rd_data (ram_rd)
  );

  assign busy  = (state != S_IDLE);
  assign new_e = '{score: item.score, tag: TAG_BITS'(item.tag)};

  always_comb begin
    left_c  = (CH_W'(pos) << 1) + CH_W'(1);
    right_c = left_c + CH_W'(1);
    cnt_c   = CH_W'(cnt);
    par_idx = IDX_W'((pos - IDX_W'(1)) >> 1);
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    pos_next   = pos;
    best_next  = best;
    itm_next   = itm;
    bestv_next = bestv;
    minv_next  = minv;
    acc_next   = acc;
    vld_next   = vld;
    finish     = 1'b0;
    ram_we     = 1'b0;
    ram_wa     = pos;
    ram_wd     = itm;
    ram_re     = 1'b0;
    ram_ra     = '0;
    sel_idx    = pos;
    sel_v      = itm;
    sel_l      = '0;
    cand_lt    = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          acc_next = 1'b0;
          vld_next = 1'b0;
          itm_next = new_e;
          if (item.func == OP_INSERT) begin
            if (cnt_c < CH_W'(CAPACITY)) begin
              acc_next = 1'b1;
              pos_next = IDX_W'(cnt);
              cnt_next = cnt + CNT_W'(1);
              if (cnt != '0) begin
                ram_re     = 1'b1;
                ram_ra     = IDX_W'((cnt - CNT_W'(1)) >> 1);
                state_next = S_UP;
              end else begin
                state_next = S_FIN;
              end
            end else begin
              ram_re     = 1'b1;
              ram_ra     = '0;
              state_next = S_ROOT;
            end
          end else if (cnt == '0) begin
            finish = 1'b1;
          end else begin
            ram_re     = 1'b1;
            ram_ra     = '0;
            state_next = S_EXT_ROOT;
          end
        end
      end

      S_ROOT: begin
        // Full heap: the new entry replaces the root only if it beats it.
        if ($signed(ram_rd.score) < $signed(itm.score)) begin
          acc_next = 1'b1;
          pos_next = '0;
          if (cnt_c > CH_W'(1)) begin
            ram_re     = 1'b1;
            ram_ra     = IDX_W'(1);
            state_next = S_DN_L;
          end else begin
            state_next = S_FIN;
          end
        end else begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_EXT_ROOT: begin
        minv_next  = ram_rd;
        vld_next   = 1'b1;
        cnt_next   = cnt - CNT_W'(1);
        ram_re     = 1'b1;
        ram_ra     = IDX_W'(cnt - CNT_W'(1));
        state_next = S_EXT_LAST;
      end

      S_EXT_LAST: begin
        // The last entry moves to the root and sifts down from there.
        itm_next = ram_rd;
        pos_next = '0;
        if (cnt_c > CH_W'(1)) begin
          ram_re     = 1'b1;
          ram_ra     = IDX_W'(1);
          state_next = S_DN_L;
        end else if (cnt == '0) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_FIN;
        end
      end

      S_UP: begin
        if ($signed(itm.score) < $signed(ram_rd.score)) begin
          // The parent drops into the hole and the hole moves up.
          ram_we   = 1'b1;
          ram_wa   = pos;
          ram_wd   = ram_rd;
          pos_next = par_idx;
          if (par_idx != '0) begin
            ram_re = 1'b1;
            ram_ra = IDX_W'((par_idx - IDX_W'(1)) >> 1);
          end else begin
            state_next = S_FIN;
          end
        end else begin
          ram_we     = 1'b1;
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_DN_L, S_DN_R: begin
        if (state == S_DN_L) begin
          cand_lt = $signed(ram_rd.score) < $signed(itm.score);
          sel_idx = cand_lt ? IDX_W'(left_c) : pos;
          sel_v   = cand_lt ? ram_rd : itm;
        end else begin
          cand_lt = $signed(ram_rd.score) < $signed(bestv.score);
          sel_idx = cand_lt ? IDX_W'(right_c) : best;
          sel_v   = cand_lt ? ram_rd : bestv;
        end
        sel_l = (CH_W'(sel_idx) << 1) + CH_W'(1);
        if (state == S_DN_L && right_c < cnt_c) begin
          best_next  = sel_idx;
          bestv_next = sel_v;
          ram_re     = 1'b1;
          ram_ra     = IDX_W'(right_c);
          state_next = S_DN_R;
        end else if (sel_idx == pos) begin
          ram_we     = 1'b1;
          finish     = 1'b1;
          state_next = S_IDLE;
        end else begin
          // The smaller child moves up into the hole.
          ram_we   = 1'b1;
          ram_wa   = pos;
          ram_wd   = sel_v;
          pos_next = sel_idx;
          if (sel_l < cnt_c) begin
            ram_re     = 1'b1;
            ram_ra     = IDX_W'(sel_l);
            state_next = S_DN_L;
          end else begin
            state_next = S_FIN;
          end
        end
      end

      S_FIN: begin
        ram_we     = 1'b1;
        finish     = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_next.accepted  = acc_next;
    res_next.valid_res = vld_next;
    res_next.min_score = vld_next ? minv_next.score : '0;
    res_next.min_tag   = vld_next ? IN_TAG_W'(minv_next.tag) : '0;
    res_next.count     = OUT_CNT_W'(cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    pos   <= pos_next;
    best  <= best_next;
    itm   <= itm_next;
    bestv <= bestv_next;
    minv  <= minv_next;
    acc   <= acc_next;
    vld   <= vld_next;
    if (finish) begin
      result <= res_next;
    end
  end

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (ram_we && ram_re) |-> (ram_wa != ram_ra))
    else $error("heap RAM read and write hit the same entry in one cycle");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    CH_W'(cnt) <= CH_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer still busy");

  a_empty_extract: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.func == OP_EXTRACT && cnt == '0)
      |=> (done && !result.valid_res && result.count == '0))
    else $error("extract on empty heap not flagged at once");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (CH_W'(ram_wa) < CH_W'(cnt)))
    else $error("heap write beyond the held entries");

endmodule

### tb/sv/tb.sv
// Self-checking testbench for top_k_min_heap_core: a heap predictor checks every result.
// Stimulus runs directed fill, replace and drain cases, then random bursts of mixed operations.
// Depends on tkh_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
  import tkh_pkg::*;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  item_t   item = '0;
  logic    done;
  result_t result;

  top_k_min_heap_core i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predicted heap contents, kept in array order like the block's memory.
  logic signed [SCORE_W-1:0] hp_score [CAPACITY];
  logic [TAG_BITS-1:0]       hp_tag   [CAPACITY];
  int                        hp_cnt = 0;

  item_t   pend_items [$];
  result_t exp_results [$];

  int n_total = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_fail = 0;
  int n_stored = 0;
  int n_dropped = 0;
  int n_popped = 0;
  int n_empty_pops = 0;

  function automatic void heap_swap(int i, int j);
    logic signed [SCORE_W-1:0] s;
    logic [TAG_BITS-1:0]       t;
    s = hp_score[i];
    t = hp_tag[i];
    hp_score[i] = hp_score[j];
    hp_tag[i] = hp_tag[j];
    hp_score[j] = s;
    hp_tag[j] = t;
  endfunction

  // Sinks the root entry; the left child is taken on a tie between children.
  function automatic void heap_sink();
    int pos;
    int best;
    pos = 0;
    while (pos < hp_cnt) begin
      best = pos;
      if (2 * pos + 1 < hp_cnt && hp_score[2 * pos + 1] < hp_score[best]) best = 2 * pos + 1;
      if (2 * pos + 2 < hp_cnt && hp_score[2 * pos + 2] < hp_score[best]) best = 2 * pos + 2;
      if (best == pos) break;
      heap_swap(pos, best);
      pos = best;
    end
  endfunction

  function automatic result_t heap_apply(item_t it);
    result_t r;
    int      pos;
    r = '0;
    if (it.func == OP_INSERT) begin
      if (hp_cnt < CAPACITY) begin
        hp_score[hp_cnt] = it.score;
        hp_tag[hp_cnt] = TAG_BITS'(it.tag);
        pos = hp_cnt;
        while (pos > 0 && hp_score[pos] < hp_score[(pos - 1) / 2]) begin
          heap_swap(pos, (pos - 1) / 2);
          pos = (pos - 1) / 2;
        end
        hp_cnt++;
        r.accepted = 1'b1;
      end else if (hp_score[0] < it.score) begin
        hp_score[0] = it.score;
        hp_tag[0] = TAG_BITS'(it.tag);
        heap_sink();
        r.accepted = 1'b1;
      end
      if (r.accepted) n_stored++;
      else n_dropped++;
    end else if (hp_cnt > 0) begin
      r.valid_res = 1'b1;
      r.min_score = hp_score[0];
      r.min_tag = IN_TAG_W'(hp_tag[0]);
      hp_score[0] = hp_score[hp_cnt - 1];
      hp_tag[0] = hp_tag[hp_cnt - 1];
      hp_cnt--;
      heap_sink();
      n_popped++;
    end else begin
      n_empty_pops++;
    end
    r.count = OUT_CNT_W'(hp_cnt);
    return r;
  endfunction

  // Sender gaps: light at first, heavy in the middle third, none at the end.
  function automatic int gap_pct();
    if (n_sent < n_total / 3) return 12;
    if (n_sent < 2 * n_total / 3) return 48;
    return 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        exp_results.push_back(heap_apply(item));
        void'(pend_items.pop_front());
        n_sent++;
      end
      if (start && busy) begin
        // Hold the transaction until the core takes it.
      end else if (pend_items.size() != 0 && $urandom_range(99) >= gap_pct()) begin
        start <= 1'b1;
        item <= pend_items[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (exp_results.size() == 0) begin
        $error("result with no transaction outstanding");
        n_fail++;
      end else begin
        want = exp_results.pop_front();
        n_checked++;
        if (result.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, result.accepted);
          n_fail++;
        end
        if (result.valid_res !== want.valid_res) begin
          $error("valid_res: expected %0d, got %0d", want.valid_res, result.valid_res);
          n_fail++;
        end
        if (result.min_score !== want.min_score) begin
          $error("min_score: expected %0d, got %0d", want.min_score, result.min_score);
          n_fail++;
        end
        if (result.min_tag !== want.min_tag) begin
          $error("min_tag: expected %0h, got %0h", want.min_tag, result.min_tag);
          n_fail++;
        end
        if (result.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, result.count);
          n_fail++;
        end
      end
    end
  end

  task automatic add_op(logic f, logic signed [SCORE_W-1:0] s, logic [IN_TAG_W-1:0] t);
    item_t it;
    it.func = f;
    it.score = s;
    it.tag = t;
    pend_items.push_back(it);
  endtask

  task automatic add_extract();
    add_op(OP_EXTRACT, $urandom, IN_TAG_W'($urandom));
  endtask

  // Mix of full-range, tie-prone small, mid-range and extreme scores.
  function automatic logic signed [SCORE_W-1:0] pick_score();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $signed($urandom_range(8)) - 4;
      7: begin
        case ($urandom_range(3))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7fff_ffff;
          2:       return 0;
          default: return -1;
        endcase
      end
      default:    return $signed($urandom_range(2000)) - 1000;
    endcase
  endfunction

  initial begin
    int burst;
    int ins_pct;
    // Directed part: empty extract, extremes, ties, full-heap drop and replace, drain.
    add_extract();
    add_op(OP_INSERT, 32'sh7fff_ffff, 16'hffff);
    add_op(OP_INSERT, 32'sh8000_0000, 16'h0000);
    add_op(OP_INSERT, 5, 16'h0001);
    add_op(OP_INSERT, 5, 16'h0002);
    add_op(OP_INSERT, -1, 16'h0003);
    add_op(OP_INSERT, 5, 16'h0004);
    add_op(OP_INSERT, 100, 16'h0005);
    add_op(OP_INSERT, -1, 16'h0006);
    add_op(OP_INSERT, 0, 16'h0007);
    add_op(OP_INSERT, 7, 16'h0008);
    add_op(OP_INSERT, 32'sh8000_0000, 16'haaaa);
    add_op(OP_INSERT, 5, 16'h5555);
    add_op(OP_INSERT, -1, 16'h1234);
    add_op(OP_INSERT, -2, 16'h4321);
    repeat (CAPACITY + 1) add_extract();
    // Random bursts that lean toward filling, churning or draining the heap.
    while (pend_items.size() < 1826) begin
      case ($urandom_range(2))
        0:       ins_pct = 85;
        1:       ins_pct = 50;
        default: ins_pct = 15;
      endcase
      burst = $urandom_range(30, 5);
      repeat (burst) begin
        if ($urandom_range(99) < ins_pct) add_op(OP_INSERT, pick_score(), IN_TAG_W'($urandom));
        else add_extract();
      end
    end
    n_total = pend_items.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pend_items.size() != 0 || exp_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d transactions, %0d results checked: %0d inserts stored, %0d dropped.",
             n_sent, n_checked, n_stored, n_dropped);
    $display("Extracts: %0d returned an entry, %0d found the heap empty.",
             n_popped, n_empty_pops);
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
